### hw/rtl/bpa_pkg.sv
// Shared constants and codes for the buddy page allocator.
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int NUM_PAGES_DEF = 1024;
    localparam int TOP_ORDER_DEF = 6;

    localparam int REF_W = 8;
    localparam logic [REF_W-1:0] REF_MAX = 8'hFF;

    // Request kinds.
    localparam logic [1:0] KIND_ALLOC  = 2'd0;
    localparam logic [1:0] KIND_FREE   = 2'd1;
    localparam logic [1:0] KIND_ADDREF = 2'd2;

    // Result status codes.
    localparam logic [2:0] STAT_GRANTED   = 3'd0;
    localparam logic [2:0] STAT_FREED     = 3'd1;
    localparam logic [2:0] STAT_DROPPED   = 3'd2;
    localparam logic [2:0] STAT_NO_MEM    = 3'd3;
    localparam logic [2:0] STAT_TOO_LARGE = 3'd4;
    localparam logic [2:0] STAT_DBL_FREE  = 3'd5;

    // Page states.
    localparam logic [1:0] PG_FREE_HEAD   = 2'd0;
    localparam logic [1:0] PG_FREE_FOLLOW = 2'd1;
    localparam logic [1:0] PG_USED_HEAD   = 2'd2;
    localparam logic [1:0] PG_USED_FOLLOW = 2'd3;

endpackage

### hw/rtl/bpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/buddy_page_allocator_unit.sv
// Top level of the buddy page allocator: request sequencer over page tables.
`timescale 1ns / 1ps
//
//  Channel   Direction  Ports                         Content
//  request   in         s_tvalid s_tready s_tdata     tdata: order, page_index
//                       s_tuser                       tuser: kind
//  result    out        m_tvalid m_tready m_tdata     tdata: block_page, granted_order
//                       m_tuser                       tuser: status
//
// After reset the block runs a clearing pass over all NUM_PAGES pages that builds the
// initial page tables; s_tready stays low during that pass.
// From acceptance to a valid result, an allocate scans the free lists from the requested order
// upward until one is not empty, unlinks that block and splits it down one level at a time;
// a failed search ends once the top order is passed. A free merges with its buddy while the
// buddy is a free head of the same order and the top order is not reached, then appends the
// block. A dropped reference, an added reference or a refused request goes straight to the
// result. The next item is accepted only in idle, after the result is registered. Every level
// costs a read of the page tables, which have one read port.
// One item is worked on at a time. A result waits in the output register while the
// next item is accepted, and the sequencer stalls only when a second result is ready.
//
// Page state lives in three memories: page info (state, order, reference count),
// next links and previous links. Only block heads carry meaningful state; the
// pages inside a block are marked as followers when a head is absorbed.

module buddy_page_allocator_unit #(
    parameter int NUM_PAGES = bpa_pkg::NUM_PAGES_DEF,
    parameter int TOP_ORDER = bpa_pkg::TOP_ORDER_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [3:0] order, [13:4] page_index, [15:14] zero
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [9:0] block_page, [12:10] granted_order, [15:13] zero
    output logic [2:0]  m_tuser    // [2:0] status
);

    localparam int AW    = $clog2(NUM_PAGES);
    localparam int LW    = AW + 1;
    localparam int OW    = $clog2(TOP_ORDER + 1);
    localparam int IW    = $clog2(TOP_ORDER + 2);
    localparam int RW    = bpa_pkg::REF_W;
    localparam int IFW   = 2 + OW + RW;
    localparam int SPAN  = 1 << TOP_ORDER;
    localparam int WHOLE = (NUM_PAGES / SPAN) * SPAN;
    localparam logic [LW-1:0] NIL   = LW'(NUM_PAGES);
    localparam logic [IW-1:0] TOP_I = IW'(TOP_ORDER);

    typedef enum logic [3:0] {
        CLEAR, IDLE, DISPATCH, SCAN, UNLINK, SPLIT, APP_A, APP_B, MARK,
        MRG_CHK, MRG_EVAL, RESP
    } state_t;

    state_t state_reg;

    logic [AW-1:0]  clr_reg;
    logic [1:0]     kind_reg;
    logic [3:0]     req_ord_reg;
    logic [9:0]     pg_reg;
    logic [IW-1:0]  ord_reg;
    logic [IW-1:0]  lvl_reg;
    logic [AW-1:0]  blk_reg;
    logic [RW-1:0]  ref_reg;
    logic [AW-1:0]  app_pg_reg;
    logic [OW-1:0]  app_lvl_reg;
    logic [LW-1:0]  app_last_reg;
    logic           from_alloc_reg;
    logic [2:0]     st_reg;
    logic [AW-1:0]  rpage_reg;
    logic [OW-1:0]  rord_reg;
    logic [LW-1:0]  first_reg [TOP_ORDER+1];
    logic [LW-1:0]  last_reg  [TOP_ORDER+1];
    logic           m_valid_reg;
    logic [15:0]    m_data_reg;
    logic [2:0]     m_user_reg;

    // Memory ports.
    logic [AW-1:0]  rd_addr;
    logic           info_we, nxt_we, prv_we;
    logic [AW-1:0]  info_wa, nxt_wa, prv_wa;
    logic [IFW-1:0] info_wd, info_rd;
    logic [LW-1:0]  nxt_wd, nxt_rd, prv_wd, prv_rd;

    // Decoded read data and helpers.
    logic [1:0]     r_st;
    logic [OW-1:0]  r_ord;
    logic [RW-1:0]  r_ref;
    logic [RW-1:0]  r_ref_inc;
    logic [RW-1:0]  blk_ref_inc;
    logic           pg_ok;
    logic [LW-1:0]  scan_first;
    logic [LW-1:0]  bud;
    logic [IW-1:0]  lvl_dn;
    logic [LW-1:0]  half;
    logic           merge_ok;
    logic [31:0]    clr_i;
    logic [1:0]     clr_st;
    logic [LW-1:0]  clr_nxt, clr_prv;

    assign r_st        = info_rd[IFW-1 -: 2];
    assign r_ord       = info_rd[RW +: OW];
    assign r_ref       = info_rd[RW-1:0];
    assign r_ref_inc   = (r_ref == bpa_pkg::REF_MAX) ? r_ref : r_ref + RW'(1);
    assign blk_ref_inc = (ref_reg == bpa_pkg::REF_MAX) ? ref_reg : ref_reg + RW'(1);
    assign pg_ok       = 32'(pg_reg) < 32'(NUM_PAGES);
    assign scan_first  = first_reg[lvl_reg[OW-1:0]];
    assign bud         = LW'(blk_reg) ^ (LW'(1) << lvl_reg);
    assign lvl_dn      = lvl_reg - IW'(1);
    assign half        = LW'(blk_reg) + (LW'(1) << lvl_dn);
    assign merge_ok    = (r_st == bpa_pkg::PG_FREE_HEAD) && (r_ord == lvl_reg[OW-1:0]);

    // Initial contents written by the clearing pass.
    assign clr_i   = 32'(clr_reg);
    assign clr_st  = (clr_i >= 32'(WHOLE)) ? bpa_pkg::PG_USED_FOLLOW :
                     ((clr_i & 32'(SPAN - 1)) != 32'd0) ? bpa_pkg::PG_FREE_FOLLOW :
                     bpa_pkg::PG_FREE_HEAD;
    assign clr_nxt = (clr_i + 32'(SPAN) < 32'(WHOLE)) ? LW'(clr_i + 32'(SPAN)) : NIL;
    assign clr_prv = (clr_i >= 32'(SPAN)) ? LW'(clr_i - 32'(SPAN)) : NIL;

    always_comb begin
        rd_addr = AW'(s_tdata[13:4]);
        info_we = 1'b0;
        info_wa = blk_reg;
        info_wd = '0;
        nxt_we  = 1'b0;
        nxt_wa  = blk_reg;
        nxt_wd  = NIL;
        prv_we  = 1'b0;
        prv_wa  = blk_reg;
        prv_wd  = NIL;
        unique case (state_reg)
            CLEAR: begin
                info_we = 1'b1;
                info_wa = clr_reg;
                info_wd = {clr_st, OW'(TOP_ORDER), RW'(0)};
                nxt_we  = 1'b1;
                nxt_wa  = clr_reg;
                nxt_wd  = clr_nxt;
                prv_we  = 1'b1;
                prv_wa  = clr_reg;
                prv_wd  = clr_prv;
            end
            DISPATCH: begin
                info_wa = AW'(pg_reg);
                if (kind_reg == bpa_pkg::KIND_FREE && pg_ok && r_ref > RW'(1)) begin
                    info_we = 1'b1;
                    info_wd = {r_st, r_ord, r_ref - RW'(1)};
                end else if (kind_reg == bpa_pkg::KIND_ADDREF && pg_ok &&
                             r_st == bpa_pkg::PG_USED_HEAD) begin
                    info_we = 1'b1;
                    info_wd = {r_st, r_ord, r_ref_inc};
                end
            end
            SCAN: begin
                rd_addr = AW'(scan_first);
            end
            UNLINK: begin
                // The taken block was the list head, so its successor loses its predecessor.
                if (nxt_rd != NIL) begin
                    prv_we = 1'b1;
                    prv_wa = AW'(nxt_rd);
                    prv_wd = NIL;
                end
            end
            APP_A: begin
                info_we = 1'b1;
                info_wa = app_pg_reg;
                info_wd = {bpa_pkg::PG_FREE_HEAD, app_lvl_reg, RW'(0)};
                prv_we  = 1'b1;
                prv_wa  = app_pg_reg;
                prv_wd  = last_reg[app_lvl_reg];
                nxt_we  = 1'b1;
                nxt_wa  = app_pg_reg;
                nxt_wd  = NIL;
            end
            APP_B: begin
                if (app_last_reg != NIL) begin
                    nxt_we = 1'b1;
                    nxt_wa = AW'(app_last_reg);
                    nxt_wd = LW'(app_pg_reg);
                end
            end
            MARK: begin
                info_we = 1'b1;
                info_wd = {bpa_pkg::PG_USED_HEAD, ord_reg[OW-1:0], blk_ref_inc};
            end
            MRG_CHK: begin
                rd_addr = AW'(bud);
            end
            MRG_EVAL: begin
                if (merge_ok) begin
                    if (prv_rd != NIL) begin
                        nxt_we = 1'b1;
                        nxt_wa = AW'(prv_rd);
                        nxt_wd = nxt_rd;
                    end
                    if (nxt_rd != NIL) begin
                        prv_we = 1'b1;
                        prv_wa = AW'(nxt_rd);
                        prv_wd = prv_rd;
                    end
                    // The higher of the two heads becomes a follower of the merged block.
                    info_we = 1'b1;
                    info_wa = (bud < LW'(blk_reg)) ? blk_reg : AW'(bud);
                    info_wd = {bpa_pkg::PG_FREE_FOLLOW, OW'(0), RW'(0)};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k <= TOP_ORDER; k++) begin
                first_reg[k] <= NIL;
                last_reg[k]  <= NIL;
            end
            if (WHOLE > 0) begin
                first_reg[TOP_ORDER] <= '0;
                last_reg[TOP_ORDER]  <= LW'(WHOLE - SPAN);
            end
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                CLEAR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (32'(clr_reg) == 32'(NUM_PAGES - 1)) begin
                        state_reg <= IDLE;
                    end
                end
                IDLE: begin
                    if (s_tvalid) begin
                        kind_reg    <= s_tuser;
                        req_ord_reg <= s_tdata[3:0];
                        pg_reg      <= s_tdata[13:4];
                        state_reg   <= DISPATCH;
                    end
                end
                DISPATCH: begin
                    rpage_reg <= '0;
                    rord_reg  <= '0;
                    st_reg    <= bpa_pkg::STAT_DBL_FREE;
                    state_reg <= RESP;
                    unique case (kind_reg)
                        bpa_pkg::KIND_ALLOC: begin
                            if (32'(req_ord_reg) > 32'(TOP_ORDER)) begin
                                st_reg <= bpa_pkg::STAT_TOO_LARGE;
                            end else begin
                                ord_reg   <= IW'(req_ord_reg);
                                lvl_reg   <= IW'(req_ord_reg);
                                state_reg <= SCAN;
                            end
                        end
                        bpa_pkg::KIND_FREE: begin
                            if (pg_ok && r_ref > RW'(1)) begin
                                st_reg <= bpa_pkg::STAT_DROPPED;
                            end else if (pg_ok && r_st == bpa_pkg::PG_USED_HEAD) begin
                                st_reg    <= bpa_pkg::STAT_FREED;
                                blk_reg   <= AW'(pg_reg);
                                lvl_reg   <= IW'(r_ord);
                                state_reg <= MRG_CHK;
                            end
                        end
                        bpa_pkg::KIND_ADDREF: begin
                            if (pg_ok && r_st == bpa_pkg::PG_USED_HEAD) begin
                                st_reg    <= bpa_pkg::STAT_GRANTED;
                                rpage_reg <= AW'(pg_reg);
                                rord_reg  <= r_ord;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                SCAN: begin
                    if (lvl_reg > TOP_I) begin
                        st_reg    <= bpa_pkg::STAT_NO_MEM;
                        state_reg <= RESP;
                    end else if (scan_first != NIL) begin
                        blk_reg   <= AW'(scan_first);
                        state_reg <= UNLINK;
                    end else begin
                        lvl_reg <= lvl_reg + IW'(1);
                    end
                end
                UNLINK: begin
                    first_reg[lvl_reg[OW-1:0]] <= nxt_rd;
                    if (nxt_rd == NIL) begin
                        last_reg[lvl_reg[OW-1:0]] <= NIL;
                    end
                    ref_reg   <= r_ref;
                    state_reg <= SPLIT;
                end
                SPLIT: begin
                    if (lvl_reg > ord_reg) begin
                        lvl_reg <= lvl_dn;
                        if (half < NIL) begin
                            app_pg_reg     <= AW'(half);
                            app_lvl_reg    <= lvl_dn[OW-1:0];
                            from_alloc_reg <= 1'b1;
                            state_reg      <= APP_A;
                        end
                    end else begin
                        state_reg <= MARK;
                    end
                end
                APP_A: begin
                    app_last_reg <= last_reg[app_lvl_reg];
                    if (last_reg[app_lvl_reg] == NIL) begin
                        first_reg[app_lvl_reg] <= LW'(app_pg_reg);
                    end
                    last_reg[app_lvl_reg] <= LW'(app_pg_reg);
                    state_reg <= APP_B;
                end
                APP_B: begin
                    state_reg <= from_alloc_reg ? SPLIT : RESP;
                end
                MARK: begin
                    st_reg    <= bpa_pkg::STAT_GRANTED;
                    rpage_reg <= blk_reg;
                    rord_reg  <= ord_reg[OW-1:0];
                    state_reg <= RESP;
                end
                MRG_CHK: begin
                    if (lvl_reg < TOP_I && bud < NIL) begin
                        state_reg <= MRG_EVAL;
                    end else begin
                        app_pg_reg     <= blk_reg;
                        app_lvl_reg    <= lvl_reg[OW-1:0];
                        from_alloc_reg <= 1'b0;
                        state_reg      <= APP_A;
                    end
                end
                MRG_EVAL: begin
                    if (merge_ok) begin
                        if (prv_rd == NIL) begin
                            first_reg[lvl_reg[OW-1:0]] <= nxt_rd;
                        end
                        if (nxt_rd == NIL) begin
                            last_reg[lvl_reg[OW-1:0]] <= prv_rd;
                        end
                        if (bud < LW'(blk_reg)) begin
                            blk_reg <= AW'(bud);
                        end
                        lvl_reg   <= lvl_reg + IW'(1);
                        state_reg <= MRG_CHK;
                    end else begin
                        app_pg_reg     <= blk_reg;
                        app_lvl_reg    <= lvl_reg[OW-1:0];
                        from_alloc_reg <= 1'b0;
                        state_reg      <= APP_A;
                    end
                end
                RESP: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_user_reg  <= st_reg;
                        m_data_reg  <= {3'b000, 3'(rord_reg), 10'(rpage_reg)};
                        state_reg   <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    bpa_ram #(.WIDTH(IFW), .DEPTH(NUM_PAGES)) u_info_ram (
        .aclk(aclk), .we(info_we), .waddr(info_wa), .wdata(info_wd),
        .raddr(rd_addr), .rdata(info_rd)
    );

    bpa_ram #(.WIDTH(LW), .DEPTH(NUM_PAGES)) u_next_ram (
        .aclk(aclk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
        .raddr(rd_addr), .rdata(nxt_rd)
    );

    bpa_ram #(.WIDTH(LW), .DEPTH(NUM_PAGES)) u_prev_ram (
        .aclk(aclk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd),
        .raddr(rd_addr), .rdata(prv_rd)
    );

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

### hw/rtl/bpa_checker.sv
// Port-level assertions for the buddy page allocator, bound to the top level.
`timescale 1ns / 1ps

module bpa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // A stalled result holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // No result is pending right after reset.
    a_reset: assert property (@(posedge aclk) $past(!aresetn) |-> !m_tvalid)
        else $error("result valid after reset");

    // The clearing pass keeps the input closed right after reset.
    a_clear: assert property (@(posedge aclk) $past(!aresetn) |-> !s_tready)
        else $error("input open during the clearing pass");

    // Status codes stay within the defined set.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= bpa_pkg::STAT_DBL_FREE)
        else $error("undefined status");

    // Only grants carry a page and an order.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != bpa_pkg::STAT_GRANTED |-> m_tdata == 16'd0)
        else $error("non-grant result carries data");

endmodule

bind buddy_page_allocator_unit bpa_checker u_bpa_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

### tb/buddy_page_allocator_unit_tb.sv
// Self-checking testbench for the buddy page allocator: directed table, exhaustion, long stall, then random traffic.
`timescale 1ns / 1ps

module buddy_page_allocator_unit_tb;

    localparam int NP = bpa_pkg::NUM_PAGES_DEF;
    localparam int TOP = bpa_pkg::TOP_ORDER_DEF;
    localparam int NIL = NP;
    localparam int N_RANDOM = 1000;
    localparam longint CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;

    buddy_page_allocator_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    typedef struct packed {
        logic [2:0] status;
        logic [9:0] page;
        logic [2:0] gorder;
    } grant_t;

    // Shadow copy of the allocator tables.
    logic [1:0]  pstat [NP];
    logic [2:0]  pord  [NP];
    logic [7:0]  refs  [NP];
    int          nxt   [NP];
    int          prv   [NP];
    int          lfirst[TOP+1];
    int          llast [TOP+1];
    int          nfree [TOP+1];

    grant_t      pending_grants[$];
    int          errors = 0;
    int          n_results = 0;
    int          n_items = 0;
    longint      cycles = 0;
    bit          rx_idle_free = 1'b0;
    bit          hold_off = 1'b0;
    bit          tx_idle_free = 1'b0;
    int          used_heads[$];

    task automatic list_unlink(int o, int p);
        if (prv[p] >= NIL) lfirst[o] = nxt[p]; else nxt[prv[p]] = nxt[p];
        if (nxt[p] >= NIL) llast[o] = prv[p]; else prv[nxt[p]] = prv[p];
        prv[p] = NIL; nxt[p] = NIL;
        if (nfree[o] > 0) nfree[o]--;
    endtask

    task automatic list_append(int o, int p);
        prv[p] = llast[o]; nxt[p] = NIL;
        if (llast[o] >= NIL) lfirst[o] = p; else nxt[llast[o]] = p;
        llast[o] = p;
        nfree[o]++;
    endtask

    task automatic shadow_reset();
        for (int o = 0; o <= TOP; o++) begin
            lfirst[o] = NIL; llast[o] = NIL; nfree[o] = 0;
        end
        for (int i = 0; i < NP; i++) begin
            pord[i] = 3'(TOP); refs[i] = 0; nxt[i] = NIL; prv[i] = NIL;
            pstat[i] = (i % (1 << TOP)) ? bpa_pkg::PG_FREE_FOLLOW : bpa_pkg::PG_FREE_HEAD;
        end
        for (int i = 0; i < NP; i += (1 << TOP)) list_append(TOP, i);
        used_heads.delete();
    endtask

    task automatic mark_span(int head, int o, logic [1:0] hs, logic [1:0] fs);
        for (int k = 0; k < (1 << o) && head + k < NP; k++) begin
            pstat[head + k] = k ? fs : hs;
            pord[head + k] = 3'(o);
        end
    endtask

    // Computes the response to one request and updates the shadow tables.
    task automatic predict_grant(input logic [1:0] kind, input logic [3:0] ord,
                                 input logic [9:0] pg, output grant_t r);
        int id, o, bud, p, i;
        r = '{bpa_pkg::STAT_DBL_FREE, 10'd0, 3'd0};
        if (kind == bpa_pkg::KIND_ALLOC) begin
            if (ord > TOP) begin
                r.status = bpa_pkg::STAT_TOO_LARGE;
            end else begin
                r.status = bpa_pkg::STAT_NO_MEM;
                for (i = ord; i <= TOP; i++) begin
                    p = lfirst[i];
                    if (nfree[i] == 0 || p >= NIL) continue;
                    list_unlink(i, p);
                    while (i > ord) begin
                        i--;
                        mark_span(p + (1 << i), i, bpa_pkg::PG_FREE_HEAD,
                                  bpa_pkg::PG_FREE_FOLLOW);
                        list_append(i, p + (1 << i));
                    end
                    mark_span(p, ord, bpa_pkg::PG_USED_HEAD, bpa_pkg::PG_USED_FOLLOW);
                    if (refs[p] != bpa_pkg::REF_MAX) refs[p]++;
                    r = '{bpa_pkg::STAT_GRANTED, p[9:0], ord[2:0]};
                    used_heads.push_back(p);
                    break;
                end
            end
        end else if (kind == bpa_pkg::KIND_FREE) begin
            if (refs[pg] > 1) begin
                refs[pg]--;
                r.status = bpa_pkg::STAT_DROPPED;
            end else if (pstat[pg] == bpa_pkg::PG_USED_HEAD) begin
                refs[pg] = 0;
                id = pg; o = pord[pg];
                while (o < TOP) begin
                    bud = id ^ (1 << o);
                    if (pstat[bud] != bpa_pkg::PG_FREE_HEAD || pord[bud] != o) break;
                    list_unlink(o, bud);
                    if (bud < id) id = bud;
                    o++;
                end
                mark_span(id, o, bpa_pkg::PG_FREE_HEAD, bpa_pkg::PG_FREE_FOLLOW);
                list_append(o, id);
                r.status = bpa_pkg::STAT_FREED;
            end
        end else if (kind == bpa_pkg::KIND_ADDREF) begin
            if (pstat[pg] == bpa_pkg::PG_USED_HEAD) begin
                if (refs[pg] != bpa_pkg::REF_MAX) refs[pg]++;
                r = '{bpa_pkg::STAT_GRANTED, pg, pord[pg]};
            end
        end
    endtask

    // Offers one request, waits for acceptance, and queues its expected result.
    // The request stays offered after acceptance until the next one or an idle gap.
    task automatic send_request(logic [1:0] kind, logic [3:0] ord, logic [9:0] pg,
                                bit idle_ok);
        grant_t r;
        if (idle_ok && !tx_idle_free && $urandom_range(99) < 15) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 15);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {2'b00, pg, ord};
        do @(posedge aclk); while (!s_tready);
        predict_grant(kind, ord, pg, r);
        pending_grants.push_back(r);
        n_items++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_grants.size() != 0);
    endtask

    // Result side: random stalls, plus a long hold-off when asked.
    always @(posedge aclk) begin
        if (!aresetn || hold_off) m_tready <= 1'b0;
        else m_tready <= rx_idle_free ? 1'b1 : ($urandom_range(99) >= 15);
    end

    always @(posedge aclk) begin
        grant_t want;
        grant_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tuser, m_tdata[9:0], m_tdata[12:10]};
            n_results++;
            if (pending_grants.size() == 0) begin
                errors++;
                $display("%0t: unexpected result status=%0d page=%0d order=%0d",
                         $time, got.status, got.page, got.gorder);
            end else begin
                want = pending_grants.pop_front();
                if (got !== want || m_tdata[15:13] !== 3'b000) begin
                    errors++;
                    $display("%0t: expected status=%0d page=%0d order=%0d,",
                             $time, want.status, want.page, want.gorder);
                    $display("    actual status=%0d page=%0d order=%0d pad=%0d",
                             got.status, got.page, got.gorder, m_tdata[15:13]);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_grants.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Directed rows: kind, order, page, whether a fixed result is known, and that result.
    typedef struct {
        logic [1:0] kind;
        logic [3:0] ord;
        logic [9:0] pg;
        bit         fixed;
        grant_t     want;
    } directed_row_t;

    directed_row_t directed_rows[] = '{
        '{bpa_pkg::KIND_ALLOC,  4'd0,  10'd0,    1'b1, '{bpa_pkg::STAT_GRANTED, 10'd0, 3'd0}},
        '{bpa_pkg::KIND_ALLOC,  4'd7,  10'd0,    1'b1, '{bpa_pkg::STAT_TOO_LARGE, 10'd0, 3'd0}},
        '{bpa_pkg::KIND_ALLOC,  4'd15, 10'd1023, 1'b1, '{bpa_pkg::STAT_TOO_LARGE, 10'd0, 3'd0}},
        '{bpa_pkg::KIND_ALLOC,  4'd6,  10'd0,    1'b0, '{bpa_pkg::STAT_GRANTED, 10'd0, 3'd0}},
        '{bpa_pkg::KIND_FREE,   4'd0,  10'd1,    1'b1, '{bpa_pkg::STAT_DBL_FREE, 10'd0, 3'd0}},
        '{bpa_pkg::KIND_FREE,   4'd0,  10'd1023, 1'b1, '{bpa_pkg::STAT_DBL_FREE, 10'd0, 3'd0}},
        '{bpa_pkg::KIND_ADDREF, 4'd0,  10'd0,    1'b1, '{bpa_pkg::STAT_GRANTED, 10'd0, 3'd0}},
        '{bpa_pkg::KIND_FREE,   4'd0,  10'd0,    1'b1, '{bpa_pkg::STAT_DROPPED, 10'd0, 3'd0}},
        '{bpa_pkg::KIND_FREE,   4'd0,  10'd0,    1'b1, '{bpa_pkg::STAT_FREED, 10'd0, 3'd0}},
        '{bpa_pkg::KIND_FREE,   4'd0,  10'd0,    1'b1, '{bpa_pkg::STAT_DBL_FREE, 10'd0, 3'd0}},
        '{bpa_pkg::KIND_ADDREF, 4'd0,  10'd5,    1'b1, '{bpa_pkg::STAT_DBL_FREE, 10'd0, 3'd0}},
        '{2'd3,                 4'd15, 10'd1023, 1'b1, '{bpa_pkg::STAT_DBL_FREE, 10'd0, 3'd0}},
        '{bpa_pkg::KIND_ALLOC,  4'd3,  10'd0,    1'b0, '{bpa_pkg::STAT_GRANTED, 10'd0, 3'd0}},
        '{bpa_pkg::KIND_ALLOC,  4'd1,  10'd0,    1'b0, '{bpa_pkg::STAT_GRANTED, 10'd0, 3'd0}},
        '{bpa_pkg::KIND_ADDREF, 4'd0,  10'd64,   1'b0, '{bpa_pkg::STAT_GRANTED, 10'd0, 3'd0}},
        '{bpa_pkg::KIND_FREE,   4'd0,  10'd64,   1'b0, '{bpa_pkg::STAT_GRANTED, 10'd0, 3'd0}},
        '{bpa_pkg::KIND_FREE,   4'd0,  10'd64,   1'b0, '{bpa_pkg::STAT_GRANTED, 10'd0, 3'd0}}
    };

    initial begin
        int pick, head;
        logic [1:0] kind;
        logic [3:0] ord;
        logic [9:0] pg;
        shadow_reset();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part; fixed rows are also cross-checked against the shadow.
        foreach (directed_rows[i]) begin
            if (directed_rows[i].fixed) begin
                for (int k = 0; k < 1; k++) begin
                    grant_t shadow_want;
                    shadow_want = directed_rows[i].want;
                    send_request(directed_rows[i].kind, directed_rows[i].ord,
                                 directed_rows[i].pg, 1'b1);
                    if (pending_grants[$] !== shadow_want) begin
                        errors++;
                        $display("%0t: row %0d table expected status=%0d page=%0d,",
                                 $time, i, shadow_want.status, shadow_want.page);
                        $display("    shadow gave status=%0d page=%0d",
                                 pending_grants[$].status, pending_grants[$].page);
                    end
                end
            end else begin
                send_request(directed_rows[i].kind, directed_rows[i].ord,
                             directed_rows[i].pg, 1'b1);
            end
        end
        drain_results();

        // Exhaust memory with top-order blocks, then ask for order-zero pages.
        repeat (17) send_request(bpa_pkg::KIND_ALLOC, 4'd6, 10'd0, 1'b1);
        repeat (8) send_request(bpa_pkg::KIND_ALLOC, 4'd0, 10'd0, 1'b1);
        drain_results();

        // Long receiver hold-off while requests keep coming.
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            begin
                int h;
                while (used_heads.size() != 0) begin
                    h = used_heads.pop_front();
                    send_request(bpa_pkg::KIND_FREE, 4'd0, 10'(h), 1'b0);
                end
                s_tvalid <= 1'b0;
            end
        join
        drain_results();

        // Random part: mostly allocate and free of live blocks, some noise.
        for (int n = 0; n < N_RANDOM; n++) begin
            tx_idle_free = (n >= 300 && n < 400);
            rx_idle_free = (n >= 500 && n < 600);
            pick = $urandom_range(99);
            ord = ($urandom_range(99) < 80) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
            pg = 10'($urandom_range(1023));
            if (pick < 45) begin
                kind = bpa_pkg::KIND_ALLOC;
            end else if (pick < 80 && used_heads.size() != 0) begin
                kind = bpa_pkg::KIND_FREE;
                head = $urandom_range(used_heads.size() - 1);
                pg = 10'(used_heads[head]);
                if (pstat[pg] == bpa_pkg::PG_USED_HEAD && refs[pg] <= 1) begin
                    used_heads.delete(head);
                end
            end else if (pick < 90 && used_heads.size() != 0) begin
                kind = bpa_pkg::KIND_ADDREF;
                pg = 10'(used_heads[$urandom_range(used_heads.size() - 1)]);
            end else begin
                kind = 2'($urandom_range(3));
            end
            if (kind == bpa_pkg::KIND_FREE && pstat[pg] != bpa_pkg::PG_USED_HEAD) begin
                for (int j = used_heads.size() - 1; j >= 0; j--) begin
                    if (used_heads[j] == pg) used_heads.delete(j);
                end
            end
            send_request(kind, ord, pg, 1'b1);
            if (n == 700) drain_results();
        end
        tx_idle_free = 1'b0;
        rx_idle_free = 1'b0;

        drain_results();
        repeat (200) @(posedge aclk);
        $display("Sent %0d requests (allocate, free, share, bad kinds, exhaustion, long stall);",
                 n_items);
        $display("checked %0d results against the shadow page tables.", n_results);
        if (errors == 0 && pending_grants.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
